/* rtl/core/ambient_light_backlight_controller_assert.svh */
// assertion macros for the ambient light backlight controller
`ifndef AMBIENT_LIGHT_BACKLIGHT_CONTROLLER_ASSERT_SVH
`define AMBIENT_LIGHT_BACKLIGHT_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define ALBC_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("albc: invariant violated");
// consequent holds in the cycle after the antecedent
`define ALBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("albc: sequence check failed");
`else
`define ALBC_ASSERT_HOLDS(label, cond)
`define ALBC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/albc_pkg.sv */
// shared types and constants of the ambient light backlight controller
package albc_pkg;

	localparam int LIGHT_BITS = 12;
	localparam int LEVEL_BITS = 8;
	localparam int LUX_BITS   = 12;
	localparam int DSOR_BITS  = 2 * LUX_BITS;

	localparam logic [3:0] FILTER_NORM = 4'd10;

	localparam logic [1:0] KIND_SET  = 2'd0;
	localparam logic [1:0] KIND_STEP = 2'd1;
	localparam logic [1:0] KIND_FADE = 2'd2;
	localparam logic [1:0] KIND_JUMP = 2'd3;

	localparam logic [2:0] REG_MIN_LEVEL  = 3'd0;
	localparam logic [2:0] REG_MAX_LEVEL  = 3'd1;
	localparam logic [2:0] REG_JUMP_THR   = 3'd2;
	localparam logic [2:0] REG_FULL_LUX   = 3'd3;
	localparam logic [2:0] REG_CUTOFF     = 3'd4;
	localparam logic [2:0] REG_FADE_EN    = 3'd5;
	localparam logic [2:0] REG_LINEAR     = 3'd6;
	localparam logic [2:0] REG_FILT_W     = 3'd7;

	localparam logic [7:0]  RST_MIN_LEVEL = 8'd15;
	localparam logic [7:0]  RST_MAX_LEVEL = 8'd255;
	localparam logic [6:0]  RST_JUMP_THR  = 7'd30;
	localparam logic [11:0] RST_FULL_LUX  = 12'd2900;
	localparam logic [3:0]  RST_FILT_W    = 4'd8;
	localparam logic [7:0]  RST_LEVEL     = 8'd120;

	typedef struct packed {
		logic [LIGHT_BITS-1:0] light_sample;
	} albc_in_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] new_level;
		logic [1:0]            update_kind;
	} albc_out_t;

endpackage

/* rtl/core/albc_stream_if.sv */
// valid/ready stream channel carrying one request payload
interface albc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ambient_light_backlight_controller.sv */
// Ambient light backlight controller. Samples arrive on sensor; every SAMPLES_PER_UPDATE
// requests the sum is averaged; unless the average exceeds a nonzero cutoff, which sets
// the target to max_level, it is mapped (linear or quadratic against full_scale_lux) and
// low-pass filtered with the previous target. The target is clamped, and one brightness
// update leaves on backlight. A sample that does not complete a group is added to the sum
// while the block stays ready; the sample that completes a group occupies the block until
// its update is loaded into the output register, including any wait for that register to
// empty. The work runs through one bit-serial restoring divider (for the average, the map
// and the filter) and one shift-add multiplier that retires one multiplier bit per cycle.
// A finished update sits in the output register while the next samples are accepted.
// Configuration writes take effect at once and belong in idle time.
`include "ambient_light_backlight_controller_assert.svh"

module ambient_light_backlight_controller
	import albc_pkg::*;
#(
	parameter int SAMPLES_PER_UPDATE = 5,
	parameter int SAMPLE_BITS        = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	albc_stream_if.sink   sensor,
	albc_stream_if.source backlight
);

	localparam int USE_W = (SAMPLE_BITS < LIGHT_BITS) ? SAMPLE_BITS : LIGHT_BITS;
	localparam int CNT_W = $clog2(SAMPLES_PER_UPDATE + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int AVG_W = SAMPLE_BITS;
	localparam int PW    = (2 * SAMPLE_BITS + 13 > 37) ? 2 * SAMPLE_BITS + 13 : 37;
	localparam int MLW   = (SAMPLE_BITS > LUX_BITS) ? SAMPLE_BITS : LUX_BITS;
	localparam int RW    = DSOR_BITS + 1;
	localparam int BC_W  = $clog2(PW + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG_DIV,
		ST_LUX_MUL,
		ST_SQR_MUL,
		ST_SCALE_MUL,
		ST_MAP_DIV,
		ST_NEW_MUL,
		ST_OLD_MUL,
		ST_FILT_DIV,
		ST_OUT
	} state_t;

	// configuration
	logic [7:0]  min_level_q;
	logic [7:0]  max_level_q;
	logic [6:0]  jump_thr_q;
	logic [11:0] full_lux_q;
	logic [11:0] cutoff_q;
	logic        fade_en_q;
	logic        linear_q;
	logic [3:0]  filt_w_q;

	// control
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [7:0]        level_q;
	logic [31:0]       last_target_q;
	logic [1:0]        kind_q;
	logic              out_valid_q;
	logic [BC_W-1:0]   bit_cnt_q;

	// datapath
	logic [PW-1:0]        acc_q;
	logic [PW-1:0]        mcand_q;
	logic [MLW-1:0]       mplier_q;
	logic [PW-1:0]        quo_q;
	logic [RW-1:0]        rem_q;
	logic [DSOR_BITS-1:0] dsor_q;
	logic [AVG_W-1:0]     avg_q;
	logic [31:0]          target_q;

	logic [SUM_W-1:0]     next_sum;
	logic [11:0]          lux_eff;
	logic [3:0]           w_eff;
	logic [3:0]           w_old;
	logic [AVG_W-1:0]     avg_now;
	logic                 cutoff_hit;
	logic                 mul_done;
	logic                 div_done;
	logic [PW-1:0]        acc_add;
	logic [RW-1:0]        trial;
	logic                 trial_ge;
	logic [31:0]          filt_sat;
	logic [31:0]          t_low;
	logic [7:0]           t_clamp;
	logic [7:0]           diff;
	logic [7:0]           level_next;
	logic [1:0]           kind_next;
	logic                 out_free;
	logic                 group_done;

	assign next_sum   = sum_q + SUM_W'(sensor.data.light_sample[USE_W-1:0]);
	assign group_done = (count_q == CNT_W'(SAMPLES_PER_UPDATE - 1));
	assign lux_eff    = (full_lux_q == '0) ? 12'd1 : full_lux_q;
	assign w_eff      = (filt_w_q > FILTER_NORM) ? FILTER_NORM : filt_w_q;
	assign w_old      = FILTER_NORM - w_eff;
	assign avg_now    = quo_q[AVG_W-1:0];
	assign cutoff_hit = (cutoff_q != '0) && (MLW'(avg_now) > MLW'(cutoff_q));
	assign mul_done   = (mplier_q == '0);
	assign div_done   = (bit_cnt_q == '0);
	assign acc_add    = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign trial      = {rem_q[RW-2:0], quo_q[PW-1]};
	assign trial_ge   = (trial >= RW'(dsor_q));
	assign filt_sat   = (|quo_q[PW-1:32]) ? '1 : quo_q[31:0];
	assign out_free   = !out_valid_q || backlight.ready;

	// clamp: min first, then max
	always_comb begin
		t_low   = (target_q < 32'(min_level_q)) ? 32'(min_level_q) : target_q;
		t_clamp = (t_low > 32'(max_level_q)) ? max_level_q : t_low[7:0];
		diff    = (level_q > t_clamp) ? level_q - t_clamp : t_clamp - level_q;
		if ((diff > 8'd1) && (diff <= 8'(jump_thr_q))) begin
			level_next = (level_q < t_clamp) ? level_q + 8'd1 : level_q - 8'd1;
			kind_next  = KIND_STEP;
		end else if (diff > 8'(jump_thr_q)) begin
			level_next = t_clamp;
			kind_next  = fade_en_q ? KIND_FADE : KIND_JUMP;
		end else begin
			level_next = t_clamp;
			kind_next  = KIND_SET;
		end
	end

	assign sensor.ready                = (state_q == ST_IDLE);
	assign backlight.valid             = out_valid_q;
	assign backlight.data.new_level    = level_q;
	assign backlight.data.update_kind  = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= RST_MIN_LEVEL;
			max_level_q <= RST_MAX_LEVEL;
			jump_thr_q  <= RST_JUMP_THR;
			full_lux_q  <= RST_FULL_LUX;
			cutoff_q    <= '0;
			fade_en_q   <= 1'b1;
			linear_q    <= 1'b1;
			filt_w_q    <= RST_FILT_W;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MIN_LEVEL: min_level_q <= cfg_data[7:0];
				REG_MAX_LEVEL: max_level_q <= cfg_data[7:0];
				REG_JUMP_THR:  jump_thr_q  <= cfg_data[6:0];
				REG_FULL_LUX:  full_lux_q  <= cfg_data;
				REG_CUTOFF:    cutoff_q    <= cfg_data;
				REG_FADE_EN:   fade_en_q   <= cfg_data[0];
				REG_LINEAR:    linear_q    <= cfg_data[0];
				REG_FILT_W:    filt_w_q    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			sum_q         <= '0;
			level_q       <= RST_LEVEL;
			last_target_q <= '0;
			kind_q        <= KIND_SET;
			out_valid_q   <= 1'b0;
			bit_cnt_q     <= '0;
		end else begin
			// a new update loaded in ST_OUT keeps the output valid
			if (out_valid_q && backlight.ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sensor.valid) begin
						if (group_done) begin
							count_q   <= '0;
							sum_q     <= '0;
							bit_cnt_q <= BC_W'(PW);
							state_q   <= ST_AVG_DIV;
						end else begin
							count_q <= count_q + CNT_W'(1);
							sum_q   <= next_sum;
						end
					end
				end
				ST_AVG_DIV: begin
					if (!div_done) begin
						bit_cnt_q <= bit_cnt_q - BC_W'(1);
					end else if (cutoff_hit) begin
						last_target_q <= 32'(max_level_q);
						state_q       <= ST_OUT;
					end else begin
						state_q <= linear_q ? ST_SCALE_MUL : ST_LUX_MUL;
					end
				end
				ST_LUX_MUL: begin
					if (mul_done) state_q <= ST_SQR_MUL;
				end
				ST_SQR_MUL: begin
					if (mul_done) state_q <= ST_SCALE_MUL;
				end
				ST_SCALE_MUL: begin
					if (mul_done) begin
						bit_cnt_q <= BC_W'(PW);
						state_q   <= ST_MAP_DIV;
					end
				end
				ST_MAP_DIV: begin
					if (!div_done) begin
						bit_cnt_q <= bit_cnt_q - BC_W'(1);
					end else begin
						state_q <= ST_NEW_MUL;
					end
				end
				ST_NEW_MUL: begin
					if (mul_done) state_q <= ST_OLD_MUL;
				end
				ST_OLD_MUL: begin
					if (mul_done) begin
						bit_cnt_q <= BC_W'(PW);
						state_q   <= ST_FILT_DIV;
					end
				end
				ST_FILT_DIV: begin
					if (!div_done) begin
						bit_cnt_q <= bit_cnt_q - BC_W'(1);
					end else begin
						last_target_q <= filt_sat;
						state_q       <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						level_q     <= level_next;
						kind_q      <= kind_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shift-add multiplier and restoring divider, one bit per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q  <= PW'(next_sum);
				rem_q  <= '0;
				dsor_q <= DSOR_BITS'(SAMPLES_PER_UPDATE);
			end
			ST_AVG_DIV, ST_MAP_DIV, ST_FILT_DIV: begin
				if (!div_done) begin
					quo_q <= {quo_q[PW-2:0], trial_ge};
					rem_q <= trial_ge ? trial - RW'(dsor_q) : trial;
				end else if (state_q == ST_AVG_DIV) begin
					avg_q    <= avg_now;
					target_q <= 32'(max_level_q);
					acc_q    <= '0;
					if (linear_q) begin
						mcand_q  <= PW'(avg_now);
						mplier_q <= MLW'(max_level_q);
						dsor_q   <= DSOR_BITS'(lux_eff);
					end else begin
						mcand_q  <= PW'(lux_eff);
						mplier_q <= MLW'(lux_eff);
					end
				end else if (state_q == ST_MAP_DIV) begin
					acc_q    <= '0;
					mcand_q  <= quo_q;
					mplier_q <= MLW'(w_eff);
				end else begin
					target_q <= filt_sat;
				end
			end
			ST_LUX_MUL, ST_SQR_MUL, ST_SCALE_MUL, ST_NEW_MUL, ST_OLD_MUL: begin
				if (!mul_done) begin
					acc_q    <= acc_add;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end else if (state_q == ST_LUX_MUL) begin
					dsor_q   <= acc_q[DSOR_BITS-1:0];
					acc_q    <= '0;
					mcand_q  <= PW'(avg_q);
					mplier_q <= MLW'(avg_q);
				end else if (state_q == ST_SQR_MUL) begin
					acc_q    <= '0;
					mcand_q  <= acc_q;
					mplier_q <= MLW'(max_level_q);
				end else if (state_q == ST_NEW_MUL) begin
					// old target term adds onto the new-value product
					mcand_q  <= PW'(last_target_q);
					mplier_q <= MLW'(w_old);
				end else begin
					quo_q  <= acc_q;
					rem_q  <= '0;
					if (state_q == ST_OLD_MUL) begin
						dsor_q <= DSOR_BITS'(FILTER_NORM);
					end
				end
			end
			default: begin
			end
		endcase
	end

	`ALBC_ASSERT_HOLDS(a_count_below_group, count_q < CNT_W'(SAMPLES_PER_UPDATE))
	`ALBC_ASSERT_NEXT(a_update_presented, (state_q == ST_OUT) && out_free,
		backlight.valid && (state_q == ST_IDLE))
	`ALBC_ASSERT_NEXT(a_step_moves_one, (state_q == ST_OUT) && out_free && (kind_next == KIND_STEP),
		(level_q == $past(level_q) + 8'd1) || (level_q == $past(level_q) - 8'd1))

endmodule

/* verif/ambient_light_backlight_controller_test.sv */
// self-checking testbench of the ambient light backlight controller
`timescale 1ns / 1ps

module ambient_light_backlight_controller_test;
	import albc_pkg::*;

	localparam int GROUP_SIZE = 5;
	// settle time covering the work of one completed group
	localparam int SETTLE_CYCLES = 3 * 37 + 49 + 60;
	localparam int TIMEOUT_NS = 20_000_000;

	typedef struct packed {
		logic [7:0]  min_level;
		logic [7:0]  max_level;
		logic [6:0]  jump_thr;
		logic [11:0] full_lux;
		logic [11:0] cutoff;
		logic        fade_en;
		logic        linear;
		logic [3:0]  weight;
	} tuning_t;

	localparam tuning_t RESET_TUNING = '{RST_MIN_LEVEL, RST_MAX_LEVEL, RST_JUMP_THR,
		RST_FULL_LUX, 12'd0, 1'b1, 1'b1, RST_FILT_W};
	localparam tuning_t LOW_TUNING = '{8'd1, 8'd1, 7'd1, 12'd1, 12'd0, 1'b0, 1'b0, 4'd1};
	localparam tuning_t HIGH_TUNING = '{8'd255, 8'd255, 7'd100, 12'd4000, 12'd3000,
		1'b1, 1'b1, 4'd9};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_data;

	albc_stream_if #(.T(albc_in_t))  sensor_ch ();
	albc_stream_if #(.T(albc_out_t)) backlight_ch ();

	ambient_light_backlight_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sensor    (sensor_ch),
		.backlight (backlight_ch)
	);

	always #4 clk = ~clk;

	// predicted state of the controller
	tuning_t     tuning;
	logic [7:0]  level_now;
	logic [31:0] prev_target;
	logic [14:0] lux_sum;
	logic [2:0]  lux_count;

	albc_out_t pending_levels[$];
	int errors = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;

	task automatic predict_level(input logic [11:0] sample);
		logic [63:0] avg;
		logic [63:0] lux;
		logic [63:0] mapped;
		logic [63:0] wgt;
		logic [63:0] filt;
		logic [31:0] goal;
		logic [31:0] gap;
		albc_out_t   res;
		lux_sum = lux_sum + sample;
		lux_count = lux_count + 3'd1;
		if (lux_count < GROUP_SIZE)
			return;
		avg = lux_sum / GROUP_SIZE;
		lux = (tuning.full_lux == 12'd0) ? 64'd1 : 64'(tuning.full_lux);
		if (tuning.cutoff != 12'd0 && avg > tuning.cutoff) begin
			prev_target = 32'(tuning.max_level);
		end else begin
			if (tuning.linear)
				mapped = avg * tuning.max_level / lux;
			else
				mapped = avg * avg * tuning.max_level / (lux * lux);
			wgt = (tuning.weight > FILTER_NORM) ? 64'(FILTER_NORM) : 64'(tuning.weight);
			filt = (wgt * mapped + (64'(FILTER_NORM) - wgt) * prev_target) / 64'(FILTER_NORM);
			prev_target = (filt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : filt[31:0];
		end
		goal = prev_target;
		if (goal < tuning.min_level)
			goal = 32'(tuning.min_level);
		if (goal > tuning.max_level)
			goal = 32'(tuning.max_level);
		gap = (level_now > goal) ? 32'(level_now) - goal : goal - 32'(level_now);
		if (gap > 1 && gap <= tuning.jump_thr) begin
			level_now = (level_now < goal) ? level_now + 8'd1 : level_now - 8'd1;
			res.update_kind = KIND_STEP;
		end else if (gap > tuning.jump_thr) begin
			level_now = goal[7:0];
			res.update_kind = tuning.fade_en ? KIND_FADE : KIND_JUMP;
		end else begin
			level_now = goal[7:0];
			res.update_kind = KIND_SET;
		end
		res.new_level = level_now;
		lux_sum = '0;
		lux_count = '0;
		pending_levels.push_back(res);
	endtask

	task automatic send_sample(input logic [11:0] sample);
		while ($urandom_range(99) < sender_idle_pct) begin
			sensor_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.data.light_sample <= sample;
		do @(posedge clk); while (!sensor_ch.ready);
		predict_level(sample);
	endtask

	// stop offering requests and wait until the block has gone quiet
	task automatic drain;
		sensor_ch.valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_tuning(input tuning_t t);
		write_reg(REG_MIN_LEVEL, 12'(t.min_level));
		write_reg(REG_MAX_LEVEL, 12'(t.max_level));
		write_reg(REG_JUMP_THR, 12'(t.jump_thr));
		write_reg(REG_FULL_LUX, t.full_lux);
		write_reg(REG_CUTOFF, t.cutoff);
		write_reg(REG_FADE_EN, 12'(t.fade_en));
		write_reg(REG_LINEAR, 12'(t.linear));
		write_reg(REG_FILT_W, 12'(t.weight));
		cfg_wr_en <= 1'b0;
		tuning = t;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
			1: begin sender_idle_pct = 54; receiver_stall_pct = 0; end
			2: begin sender_idle_pct = 0; receiver_stall_pct = 54; end
			default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
		endcase
	endtask

	// mostly inside the usual range, often at its ends, now and then anywhere in the field
	function automatic int draw_setting(input int lo, input int hi, input int top);
		int pick;
		pick = $urandom_range(9);
		if (pick < 2)
			return lo;
		if (pick < 4)
			return hi;
		if (pick == 4)
			return $urandom_range(top);
		return $urandom_range(hi, lo);
	endfunction

	function automatic tuning_t draw_tuning();
		tuning_t t;
		t.min_level = 8'(draw_setting(1, 255, 255));
		t.max_level = 8'(draw_setting(1, 255, 255));
		t.jump_thr = 7'(draw_setting(1, 100, 127));
		t.full_lux = 12'(draw_setting(1, 4000, 4095));
		t.cutoff = ($urandom_range(2) == 0) ? 12'(draw_setting(0, 3000, 4095)) : 12'd0;
		t.fade_en = 1'($urandom_range(1));
		t.linear = 1'($urandom_range(1));
		t.weight = 4'(draw_setting(1, 9, 15));
		return t;
	endfunction

	task automatic test_default_settings;
		repeat (GROUP_SIZE) send_sample(12'd0);
		repeat (GROUP_SIZE) send_sample(12'hFFF);
		send_sample(12'hAAA);
		send_sample(12'h555);
		send_sample(12'hAAA);
		send_sample(12'h555);
		send_sample(12'hAAA);
		drain();
	endtask

	task automatic test_corner_settings;
		// zero full scale, zero floor, oversized weight, zero threshold, quadratic, no fade
		load_tuning('{8'd0, 8'd255, 7'd0, 12'd0, 12'd0, 1'b0, 1'b0, 4'd15});
		repeat (GROUP_SIZE) send_sample(12'd0);
		drain();
		// cutoff hit with crossed limits, then a zero weight holding the old target
		load_tuning('{8'd200, 8'd50, 7'd127, 12'd4095, 12'd100, 1'b1, 1'b1, 4'd0});
		repeat (GROUP_SIZE) send_sample(12'hFFF);
		repeat (GROUP_SIZE) send_sample(12'd50);
		drain();
	endtask

	task automatic test_random_traffic;
		int base;
		int sample;
		int count;
		base = $urandom_range(4095);
		for (int phase = 0; phase < 16; phase++) begin
			if (phase == 0)
				load_tuning(RESET_TUNING);
			else if (phase == 1)
				load_tuning(LOW_TUNING);
			else if (phase == 2)
				load_tuning(HIGH_TUNING);
			else
				load_tuning(draw_tuning());
			set_idling(phase % 4);
			count = $urandom_range(120, 80);
			for (int i = 0; i < count; i++) begin
				// slowly drifting light level so steps and holds show up, with jumps
				if ($urandom_range(19) == 0)
					base = $urandom_range(4095);
				else if ($urandom_range(4) == 0)
					base = base + $urandom_range(400) - 200;
				if (base < 0)
					base = 0;
				if (base > 4095)
					base = 4095;
				if ($urandom_range(9) == 0)
					sample = $urandom_range(4095);
				else
					sample = base + $urandom_range(64) - 32;
				if (sample < 0)
					sample = 0;
				if (sample > 4095)
					sample = 4095;
				send_sample(12'(sample));
			end
			drain();
		end
	endtask

	task automatic test_backpressure;
		load_tuning(RESET_TUNING);
		set_idling(0);
		hold_request = 1500;
		for (int i = 0; i < 8 * GROUP_SIZE; i++)
			send_sample(12'($urandom_range(4095)));
		drain();
	endtask

	initial begin : result_checker
		albc_out_t want;
		albc_out_t got;
		forever begin
			@(posedge clk);
			if (backlight_ch.valid && backlight_ch.ready) begin
				got = backlight_ch.data;
				if (pending_levels.size() == 0) begin
					errors++;
					$display("%0t: unexpected update, expected none, actual level %0d kind %0d",
						$time, got.new_level, got.update_kind);
				end else begin
					want = pending_levels.pop_front();
					if (got.new_level !== want.new_level) begin
						errors++;
						$display("%0t: new_level expected %0d actual %0d",
							$time, want.new_level, got.new_level);
					end
					if (got.update_kind !== want.update_kind) begin
						errors++;
						$display("%0t: update_kind expected %0d actual %0d",
							$time, want.update_kind, got.update_kind);
					end
				end
			end
		end
	end

	// receiver readiness, with a long hold counted in cycles on request
	initial begin : receiver_stall
		int hold_left;
		hold_left = 0;
		backlight_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				backlight_ch.ready <= 1'b0;
			end else begin
				backlight_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_MIN_LEVEL;
		cfg_data <= '0;
		sensor_ch.valid <= 1'b0;
		sensor_ch.data <= '0;
		tuning = RESET_TUNING;
		level_now = RST_LEVEL;
		prev_target = '0;
		lux_sum = '0;
		lux_count = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_corner_settings();
		test_random_traffic();
		test_backpressure();

		if (errors == 0)
			$display("ambient_light_backlight_controller_test: done, clean");
		else
			$display("ambient_light_backlight_controller_test: done, errors");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("ambient_light_backlight_controller_test: done, errors");
		$finish;
	end

endmodule
